// ===== rtl/dmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants of the max-flow engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmf_pkg;

   localparam int MaxNodes  = 64;
   localparam int MaxEdges  = 256;
   localparam int ArcSlots  = 2 * MaxEdges;
   localparam int NodeW     = $clog2(MaxNodes);
   localparam int ArcW      = $clog2(ArcSlots) + 1;   // holds the nil marker
   localparam int ArcAw     = ArcW - 1;
   localparam int CapW      = 31;
   localparam int LvlW      = NodeW + 1;
   localparam int SpW       = NodeW + 1;

   localparam logic [ArcW-1:0] ArcNil  = ArcW'(ArcSlots);
   localparam logic [CapW-1:0] CapMax  = {CapW{1'b1}};

   localparam logic [1:0] OpAdd     = 2'd0;
   localparam logic [1:0] OpRestore = 2'd1;
   localparam logic [1:0] OpRun     = 2'd2;

   localparam logic [1:0] StDone     = 2'd0;
   localparam logic [1:0] StSelfLoop = 2'd1;
   localparam logic [1:0] StFull     = 2'd2;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MIN = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [NodeW-1:0] node;
      logic [ArcW-1:0]  cur;
      logic [CapW-1:0]  f;
      logic [CapW-1:0]  fu;
      logic [LvlW-1:0]  lvl;
   } frame_type;

endpackage

`default_nettype wire

// ===== rtl/dmf_alu.sv =====
// ----------------------------------------------------------------------------
// dmf_alu
// Shared add / subtract / minimum unit used by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmf_alu (
   input  wire dmf_pkg::alu_req_type req,
   output logic [31:0]               y
);
   import dmf_pkg::*;

   always_comb begin
      unique case (req.op)
         ALU_ADD: y = req.a + req.b;
         ALU_SUB: y = req.a - req.b;
         ALU_MIN: y = (req.a < req.b) ? req.a : req.b;
         default: y = req.a;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dinic_max_flow_top.sv =====
// ----------------------------------------------------------------------------
// dinic_max_flow_top
// Dinic max-flow engine: edge store, capacity restore, level-graph BFS and
// stack-based blocking-flow DFS under one sequencer.
// ----------------------------------------------------------------------------
// Add edge: a self loop, a full store or an unused op goes straight to the
// result word. Restore visits each stored arc. Run: data dependent; arcs scanned
// in BFS, dequeued nodes and DFS steps are all serialized on the arc memories
// (one read and one write port each) and the shared ALU.
// One item at a time; a new word is taken while the last result waits.
// Reset (synchronous) empties the graph: arc count 0, all node lists empty.
`timescale 1ns / 1ps
`default_nettype none

module dinic_max_flow_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0] from_node[7:2] to_node[13:8] capacity[44:14]
   // source_node[50:45] sink_node[56:51]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0] max_flow[32:2]
   output logic [39:0]      rsp_tdata
);
   import dmf_pkg::*;

   typedef enum logic [24:0] {
      S_IDLE     = 25'h0000001, S_ADD0     = 25'h0000002, S_ADD1    = 25'h0000004,
      S_ADD2     = 25'h0000008, S_RST0     = 25'h0000010, S_RST1    = 25'h0000020,
      S_BFS_INIT = 25'h0000040, S_BFS_POP  = 25'h0000080, S_BFS_U   = 25'h0000100,
      S_BFS_A0   = 25'h0000200, S_BFS_A1   = 25'h0000400, S_BFS_A2  = 25'h0000800,
      S_DFS_INIT = 25'h0001000, S_DFS_I1   = 25'h0002000, S_DFS_TOP = 25'h0004000,
      S_DFS_ARC  = 25'h0008000, S_DFS_ARC2 = 25'h0010000, S_DFS_RET = 25'h0020000,
      S_DFS_POP  = 25'h0040000, S_DFS_R1   = 25'h0080000, S_DFS_R2  = 25'h0100000,
      S_DFS_R3   = 25'h0200000, S_ACC      = 25'h0400000, S_FIN     = 25'h0800000,
      S_DONE     = 25'h1000000
   } state_type;

   // memories
   logic [NodeW-1:0] arc_head_mem [ArcSlots];
   logic [CapW-1:0]  arc_res_mem  [ArcSlots];
   logic [CapW-1:0]  arc_cap_mem  [ArcSlots];
   logic [ArcW-1:0]  arc_next_mem [ArcSlots];
   logic [ArcW-1:0]  nf_mem       [MaxNodes];
   logic [LvlW-1:0]  lvl_mem      [MaxNodes];
   logic [NodeW-1:0] queue_mem    [MaxNodes];
   frame_type        stack_mem    [MaxNodes];

   // memory ports
   logic             arc_we, res_we, lvl_we, q_we, stk_we, nf_we;
   logic [ArcAw-1:0] arc_waddr, res_waddr, arc_raddr, res_raddr;
   logic             arc_re, res_re, cap_re, nf_re, lvl_re, q_re, stk_re;
   logic [NodeW-1:0] arc_whead;
   logic [CapW-1:0]  arc_wcap, res_wdata;
   logic [ArcW-1:0]  arc_wnext;
   logic [NodeW-1:0] nf_waddr, nf_raddr, lvl_waddr, lvl_raddr, q_waddr, q_raddr;
   logic [ArcW-1:0]  nf_wdata;
   logic [LvlW-1:0]  lvl_wdata;
   logic [NodeW-1:0] q_wdata, stk_waddr, stk_raddr;
   frame_type        stk_wdata;

   logic [NodeW-1:0] head_q;
   logic [CapW-1:0]  res_q, cap_q;
   logic [ArcW-1:0]  next_q, nf_q;
   logic             nf_vld_q;
   logic [LvlW-1:0]  lvl_q;
   logic [NodeW-1:0] qd_q;
   frame_type        stk_q;
   logic [ArcW-1:0]  nf_eff;

   // control and working registers
   state_type        state_ff, state_in;
   logic [ArcW-1:0]  cnt_ff, cnt_in;
   logic [MaxNodes-1:0] nf_vld_ff, nf_vld_in;
   logic [MaxNodes-1:0] ok_ff, ok_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [39:0]      rsp_data_ff, rsp_data_in;
   logic [SpW-1:0]   sp_ff, sp_in;
   logic [SpW-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [ArcW-1:0]  a_ff, a_in;
   logic [NodeW-1:0] u_ff, u_in;
   logic [LvlW-1:0]  ulvl_ff, ulvl_in;
   frame_type        top_ff, top_in;
   logic [NodeW-1:0] av_ff, av_in;
   logic [CapW-1:0]  ares_ff, ares_in;
   logic [ArcW-1:0]  anx_ff, anx_in;
   logic [CapW-1:0]  ret_ff, ret_in;
   logic [31:0]      acc_ff, acc_in;
   logic [1:0]       status_ff, status_in;
   logic [63:0]      item_ff, item_in;

   logic [1:0]       op_w;
   logic [NodeW-1:0] from_w, to_w, src_w, sink_w;
   logic [CapW-1:0]  cap_w;

   alu_req_type      alu_req;
   logic [31:0]      alu_y;
   logic             out_free, dfs_ok;
   logic [CapW-1:0]  ret_w;

   dmf_alu u_alu (.req(alu_req), .y(alu_y));

   assign op_w   = item_ff[1:0];
   assign from_w = item_ff[7:2];
   assign to_w   = item_ff[13:8];
   assign cap_w  = item_ff[44:14];
   assign src_w  = item_ff[50:45];
   assign sink_w = item_ff[56:51];

   assign nf_eff     = nf_vld_q ? nf_q : ArcNil;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (arc_we) begin
         arc_head_mem[arc_waddr] <= arc_whead;
         arc_cap_mem[arc_waddr]  <= arc_wcap;
         arc_next_mem[arc_waddr] <= arc_wnext;
      end
      if (res_we) arc_res_mem[res_waddr] <= res_wdata;
      if (arc_re) begin
         head_q <= arc_head_mem[arc_raddr];
         next_q <= arc_next_mem[arc_raddr];
      end
      if (cap_re) cap_q <= arc_cap_mem[arc_raddr];
      if (res_re) res_q <= arc_res_mem[res_raddr];
      if (nf_we) nf_mem[nf_waddr] <= nf_wdata;
      if (nf_re) begin
         nf_q     <= nf_mem[nf_raddr];
         nf_vld_q <= nf_vld_ff[nf_raddr];
      end
      if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
      if (lvl_re) lvl_q <= lvl_mem[lvl_raddr];
      if (q_we) queue_mem[q_waddr] <= q_wdata;
      if (q_re) qd_q <= queue_mem[q_raddr];
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      if (stk_re) stk_q <= stack_mem[stk_raddr];
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      nf_vld_in   = nf_vld_ff;
      ok_in       = ok_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      sp_in       = sp_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      a_in        = a_ff;
      u_in        = u_ff;
      ulvl_in     = ulvl_ff;
      top_in      = top_ff;
      av_in       = av_ff;
      ares_in     = ares_ff;
      anx_in      = anx_ff;
      ret_in      = ret_ff;
      acc_in      = acc_ff;
      status_in   = status_ff;
      item_in     = item_ff;

      arc_we = 1'b0; res_we = 1'b0; lvl_we = 1'b0; q_we = 1'b0;
      stk_we = 1'b0; nf_we = 1'b0;
      arc_re = 1'b0; res_re = 1'b0; cap_re = 1'b0; nf_re = 1'b0;
      lvl_re = 1'b0; q_re = 1'b0; stk_re = 1'b0;
      arc_waddr = cnt_ff[ArcAw-1:0];
      res_waddr = cnt_ff[ArcAw-1:0];
      arc_raddr = a_ff[ArcAw-1:0];
      res_raddr = a_ff[ArcAw-1:0];
      arc_whead = to_w;
      arc_wcap  = cap_w;
      arc_wnext = nf_eff;
      res_wdata = cap_w;
      nf_waddr  = from_w;
      nf_raddr  = from_w;
      nf_wdata  = cnt_ff;
      lvl_waddr = src_w;
      lvl_raddr = u_ff;
      lvl_wdata = '0;
      q_waddr   = wr_ff[NodeW-1:0];
      q_raddr   = rd_ff[NodeW-1:0];
      q_wdata   = src_w;
      stk_waddr = NodeW'(sp_ff - SpW'(1));
      stk_raddr = NodeW'(sp_ff - SpW'(2));
      stk_wdata = top_ff;

      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;

      dfs_ok = res_q != '0;
      ret_w  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in   = req_tdata;
               status_in = StDone;
               acc_in    = '0;
               a_in      = '0;
               unique case (req_tdata[1:0])
                  OpAdd: begin
                     if (req_tdata[7:2] == req_tdata[13:8]) begin
                        status_in = StSelfLoop;
                        state_in  = S_DONE;
                     end else if (cnt_ff + ArcW'(2) > ArcNil) begin
                        status_in = StFull;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ADD0;
                     end
                  end
                  OpRestore: state_in = (cnt_ff == '0) ? S_DONE : S_RST0;
                  OpRun:     state_in = S_BFS_INIT;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ADD0: begin
            nf_re    = 1'b1;
            state_in = S_ADD1;
         end
         S_ADD1: begin
            arc_we = 1'b1;
            res_we = 1'b1;
            nf_we  = 1'b1;
            nf_vld_in[from_w] = 1'b1;
            nf_re    = 1'b1;
            nf_raddr = to_w;
            state_in = S_ADD2;
         end
         S_ADD2: begin
            arc_we    = 1'b1;
            res_we    = 1'b1;
            arc_waddr = ArcAw'(cnt_ff + ArcW'(1));
            res_waddr = ArcAw'(cnt_ff + ArcW'(1));
            arc_whead = from_w;
            arc_wcap  = '0;
            res_wdata = '0;
            nf_we     = 1'b1;
            nf_waddr  = to_w;
            nf_wdata  = cnt_ff + ArcW'(1);
            nf_vld_in[to_w] = 1'b1;
            cnt_in   = cnt_ff + ArcW'(2);
            state_in = S_DONE;
         end
         S_RST0: begin
            cap_re   = 1'b1;
            state_in = S_RST1;
         end
         S_RST1: begin
            res_we    = 1'b1;
            res_waddr = a_ff[ArcAw-1:0];
            res_wdata = cap_q;
            a_in      = a_ff + ArcW'(1);
            state_in  = (a_ff + ArcW'(1) >= cnt_ff) ? S_DONE : S_RST0;
         end
         S_BFS_INIT: begin
            ok_in         = '0;
            ok_in[src_w]  = 1'b1;
            lvl_we        = 1'b1;
            q_we          = 1'b1;
            q_waddr       = '0;
            rd_in         = '0;
            wr_in         = SpW'(1);
            state_in      = S_BFS_POP;
         end
         S_BFS_POP: begin
            if (rd_ff < wr_ff) begin
               q_re     = 1'b1;
               rd_in    = rd_ff + SpW'(1);
               state_in = S_BFS_U;
            end else begin
               state_in = S_FIN;
            end
         end
         S_BFS_U: begin
            u_in      = qd_q;
            nf_re     = 1'b1;
            nf_raddr  = qd_q;
            lvl_re    = 1'b1;
            lvl_raddr = qd_q;
            state_in  = S_BFS_A0;
         end
         S_BFS_A0: begin
            ulvl_in  = lvl_q;
            a_in     = nf_eff;
            state_in = S_BFS_A1;
         end
         S_BFS_A1: begin
            if (a_ff < cnt_ff) begin
               arc_re   = 1'b1;
               res_re   = 1'b1;
               state_in = S_BFS_A2;
            end else begin
               state_in = S_BFS_POP;
            end
         end
         S_BFS_A2: begin
            a_in     = next_q;
            state_in = S_BFS_A1;
            if (res_q != '0 && !ok_ff[head_q]) begin
               ok_in[head_q] = 1'b1;
               lvl_we        = 1'b1;
               lvl_waddr     = head_q;
               lvl_wdata     = ulvl_ff + LvlW'(1);
               if (head_q == sink_w) begin
                  state_in = S_DFS_INIT;
               end else if (wr_ff < SpW'(MaxNodes)) begin
                  q_we    = 1'b1;
                  q_wdata = head_q;
                  wr_in   = wr_ff + SpW'(1);
               end
            end
         end
         S_DFS_INIT: begin
            nf_re    = 1'b1;
            nf_raddr = src_w;
            state_in = S_DFS_I1;
         end
         S_DFS_I1: begin
            top_in.node = src_w;
            top_in.cur  = nf_eff;
            top_in.f    = CapMax;
            top_in.fu   = CapMax;
            top_in.lvl  = '0;
            sp_in       = SpW'(1);
            state_in    = S_DFS_TOP;
         end
         S_DFS_TOP: begin
            if (top_ff.node != sink_w && top_ff.fu != '0 && top_ff.cur < cnt_ff) begin
               arc_re    = 1'b1;
               res_re    = 1'b1;
               arc_raddr = top_ff.cur[ArcAw-1:0];
               res_raddr = top_ff.cur[ArcAw-1:0];
               state_in  = S_DFS_ARC;
            end else begin
               state_in = S_DFS_RET;
            end
         end
         S_DFS_ARC: begin
            av_in     = head_q;
            ares_in   = res_q;
            anx_in    = next_q;
            lvl_re    = 1'b1;
            lvl_raddr = head_q;
            nf_re     = 1'b1;
            nf_raddr  = head_q;
            state_in  = S_DFS_ARC2;
         end
         S_DFS_ARC2: begin
            dfs_ok = ares_ff != '0 && ok_ff[av_ff] &&
                     lvl_q == top_ff.lvl + LvlW'(1) && sp_ff < SpW'(MaxNodes);
            alu_req.op = ALU_MIN;
            alu_req.a  = {1'b0, top_ff.fu};
            alu_req.b  = {1'b0, ares_ff};
            if (dfs_ok) begin
               stk_we      = 1'b1;
               top_in.node = av_ff;
               top_in.cur  = nf_eff;
               top_in.f    = alu_y[CapW-1:0];
               top_in.fu   = alu_y[CapW-1:0];
               top_in.lvl  = top_ff.lvl + LvlW'(1);
               sp_in       = sp_ff + SpW'(1);
            end else begin
               top_in.cur = anx_ff;
            end
            state_in = S_DFS_TOP;
         end
         S_DFS_RET: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, top_ff.f};
            alu_req.b  = {1'b0, top_ff.fu};
            if (top_ff.node == sink_w) begin
               ret_w = top_ff.f;
            end else begin
               ret_w = alu_y[CapW-1:0];
               if (ret_w == '0) ok_in[top_ff.node] = 1'b0;
            end
            ret_in = ret_w;
            sp_in  = sp_ff - SpW'(1);
            if (sp_ff == SpW'(1)) begin
               state_in = S_ACC;
            end else begin
               stk_re   = 1'b1;
               state_in = S_DFS_POP;
            end
         end
         S_DFS_POP: begin
            top_in    = stk_q;
            arc_re    = 1'b1;
            res_re    = 1'b1;
            arc_raddr = stk_q.cur[ArcAw-1:0];
            res_raddr = stk_q.cur[ArcAw-1:0];
            state_in  = S_DFS_R1;
         end
         S_DFS_R1: begin
            anx_in = next_q;
            if (ret_ff != '0) begin
               alu_req.op = ALU_SUB;
               alu_req.a  = {1'b0, res_q};
               alu_req.b  = {1'b0, ret_ff};
               res_we     = 1'b1;
               res_waddr  = top_ff.cur[ArcAw-1:0];
               res_wdata  = alu_y[CapW-1:0];
               res_re     = 1'b1;
               res_raddr  = top_ff.cur[ArcAw-1:0] ^ ArcAw'(1);
               state_in   = S_DFS_R2;
            end else begin
               top_in.cur = next_q;
               state_in   = S_DFS_TOP;
            end
         end
         S_DFS_R2: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {1'b0, res_q};
            alu_req.b  = {1'b0, ret_ff};
            res_we     = 1'b1;
            res_waddr  = top_ff.cur[ArcAw-1:0] ^ ArcAw'(1);
            res_wdata  = alu_y[CapW-1:0];
            state_in   = S_DFS_R3;
         end
         S_DFS_R3: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, top_ff.fu};
            alu_req.b  = {1'b0, ret_ff};
            top_in.fu  = alu_y[CapW-1:0];
            top_in.cur = anx_ff;
            state_in   = S_DFS_TOP;
         end
         S_ACC: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = acc_ff;
            alu_req.b  = {1'b0, ret_ff};
            // saturate one above the cap so later phases cannot wrap
            acc_in   = alu_y[31] ? 32'h8000_0000 : alu_y;
            state_in = S_BFS_INIT;
         end
         S_FIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {7'd0, (op_w == OpRun) ?
                              (acc_ff[31] ? CapMax : acc_ff[CapW-1:0]) : CapW'(0),
                              status_ff};
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         nf_vld_ff  <= '0;
         ok_ff      <= '0;
         rsp_vld_ff <= 1'b0;
         sp_ff      <= '0;
         rd_ff      <= '0;
         wr_ff      <= '0;
         acc_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         nf_vld_ff  <= nf_vld_in;
         ok_ff      <= ok_in;
         rsp_vld_ff <= rsp_vld_in;
         sp_ff      <= sp_in;
         rd_ff      <= rd_in;
         wr_ff      <= wr_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      a_ff        <= a_in;
      u_ff        <= u_in;
      ulvl_ff     <= ulvl_in;
      top_ff      <= top_in;
      av_ff       <= av_in;
      ares_ff     <= ares_in;
      anx_ff      <= anx_in;
      ret_ff      <= ret_in;
      status_ff   <= status_in;
      item_ff     <= item_in;
   end

   a_cnt_even: assert property (@(posedge clock) disable iff (reset) !cnt_ff[0])
      else $error("arc count odd");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= ArcNil)
      else $error("arc count overflow");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpW'(MaxNodes))
      else $error("dfs stack overflow");
   a_acc_sat: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= 32'h8000_0000)
      else $error("flow accumulator past saturation");
   a_pop_sp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DFS_POP |-> sp_ff != '0)
      else $error("pop from empty stack");

endmodule

`default_nettype wire
